/* src/pds_pkg.sv */
// Shared constants and controller/datapath interface types for the PLL divider search.
// Used by pds_ctrl, pds_datapath and pll_divider_search_core. No dependencies.
`default_nettype none

package pds_pkg;

  // Default search limits for the feedback and post dividers.
  localparam int unsigned FbDivMaxDefault   = 320;
  localparam int unsigned FbDivMinDefault   = 16;
  localparam int unsigned PostDivMaxDefault = 7;

  // Fixed field widths.
  localparam int unsigned RefW    = 16;
  localparam int unsigned TargetW = 21;
  localparam int unsigned VcoHzW  = 31;
  localparam int unsigned PostW   = 3;

  // VCO window in kHz and the kHz to Hz scale.
  localparam int unsigned VcoMinKhz = 400000;
  localparam int unsigned VcoMaxKhz = 1600000;
  localparam int unsigned KhzToHz   = 1000;

  // Reset value of the reference frequency register.
  localparam logic [RefW-1:0] RefResetKhz = 16'd12000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new request and start the scan
    logic step;     // move to the next feedback divider
    logic capture;  // latch the outcome of the scan
    logic emit;     // drive the result registers
  } pds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;    // divider range holds no value
    logic last;     // current feedback divider is the final one
    logic hit;      // a post divider pair matches at the current divider
  } pds_status_t;

endpackage

`default_nettype wire

/* src/pds_ctrl.sv */
// Controller state machine for the PLL divider search.
// Depends on pds_pkg for the command and status types.
`default_nettype none

module pds_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire pds_pkg::pds_status_t status_i,
  output pds_pkg::pds_cmd_t         cmd_o,
  output logic                      busy_o
);
  import pds_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.empty ? StDone : StRun;
        end
      end
      StRun: begin
        if (status_i.hit || status_i.last) begin
          cmd_o.capture = 1'b1;
          state_d       = StDone;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

`default_nettype wire

/* src/pds_datapath.sv */
// Datapath for the PLL divider search: reference register, feedback divider scan,
// parallel post divider comparison and result registers. Depends on pds_pkg.
`default_nettype none

module pds_datapath #(
  parameter int unsigned FB_DIV_MAX   = pds_pkg::FbDivMaxDefault,
  parameter int unsigned FB_DIV_MIN   = pds_pkg::FbDivMinDefault,
  parameter int unsigned POST_DIV_MAX = pds_pkg::PostDivMaxDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          ref_we_i,
  input  wire  [pds_pkg::RefW-1:0]     ref_wdata_i,
  input  wire  [pds_pkg::TargetW-1:0]  target_khz_i,
  input  wire  pds_pkg::pds_cmd_t      cmd_i,
  output pds_pkg::pds_status_t         status_o,
  output logic                         valid_o,
  output logic                         found_o,
  output logic [pds_pkg::VcoHzW-1:0]   vco_hz_o,
  output logic [pds_pkg::PostW-1:0]    pdiv1_o,
  output logic [pds_pkg::PostW-1:0]    pdiv2_o
);
  import pds_pkg::*;

  localparam int unsigned FbW    = $clog2(FB_DIV_MAX + 1);
  localparam int unsigned VcoW   = FbW + RefW;
  localparam int unsigned ProdW  = TargetW + $clog2(POST_DIV_MAX * POST_DIV_MAX + 1);
  localparam int unsigned CmpW   = (VcoW > ProdW) ? VcoW : ProdW;
  localparam int unsigned ScaleW = VcoW + 10;

  logic [RefW-1:0]    ref_q;
  logic [TargetW-1:0] target_q;
  logic [FbW-1:0]     fb_q;
  logic [VcoW-1:0]    vco_q;
  logic               hit_q;
  logic [VcoW-1:0]    hit_vco_q;
  logic [PostW-1:0]   hit_p1_q, hit_p2_q;
  logic               valid_q, found_q;
  logic [VcoHzW-1:0]  vco_hz_q;
  logic [PostW-1:0]   p1_q, p2_q;

  logic [CmpW-1:0]    vco_ext;
  logic               in_window;
  logic               any_match;
  logic [PostW-1:0]   sel_p1, sel_p2;
  logic [ScaleW-1:0]  vco_scaled;

  // Reference frequency register, written by the user while the block is idle; unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= RefResetKhz;
    end else if (ref_we_i) begin
      ref_q <= ref_wdata_i;
    end
  end

  // Window check on the current VCO value.
  assign vco_ext   = CmpW'(vco_q);
  assign in_window = (vco_ext >= CmpW'(VcoMinKhz)) && (vco_ext <= CmpW'(VcoMaxKhz));

  // Compare every post divider pair at once; the first pair in scan order wins.
  always_comb begin
    logic [CmpW-1:0] prod;
    any_match = 1'b0;
    sel_p1    = '0;
    sel_p2    = '0;
    for (int p1 = POST_DIV_MAX; p1 >= 1; p1--) begin
      for (int p2 = p1; p2 >= 1; p2--) begin
        prod = CmpW'(target_q) * CmpW'(p1 * p2);
        if (!any_match && (prod == vco_ext)) begin
          any_match = 1'b1;
          sel_p1    = PostW'(p1);
          sel_p2    = PostW'(p2);
        end
      end
    end
  end

  assign status_o.empty = (FB_DIV_MIN > FB_DIV_MAX);
  assign status_o.last  = (fb_q == FbW'(FB_DIV_MIN));
  assign status_o.hit   = in_window && any_match;

  // Feedback divider scan: the VCO value steps down by one reference on each step command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= target_khz_i;
      fb_q     <= FbW'(FB_DIV_MAX);
      vco_q    <= VcoW'(FB_DIV_MAX) * VcoW'(ref_q);
    end else if (cmd_i.step) begin
      fb_q  <= fb_q - FbW'(1);
      vco_q <= vco_q - VcoW'(ref_q);
    end
  end

  // Outcome of the scan; cleared at the start so a miss reports zeros.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_q     <= 1'b0;
      hit_vco_q <= '0;
      hit_p1_q  <= '0;
      hit_p2_q  <= '0;
    end else if (cmd_i.capture && status_o.hit) begin
      hit_q     <= 1'b1;
      hit_vco_q <= vco_q;
      hit_p1_q  <= sel_p1;
      hit_p2_q  <= sel_p2;
    end
  end

  // Scale the chosen VCO from kHz to Hz.
  assign vco_scaled = ScaleW'(hit_vco_q) * ScaleW'(KhzToHz);

  // Result registers and the one-cycle strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q  <= hit_q;
      vco_hz_q <= vco_scaled[VcoHzW-1:0];
      p1_q     <= hit_p1_q;
      p2_q     <= hit_p2_q;
    end
  end

  assign valid_o  = valid_q;
  assign found_o  = found_q;
  assign vco_hz_o = vco_hz_q;
  assign pdiv1_o  = p1_q;
  assign pdiv2_o  = p2_q;

endmodule

`default_nettype wire

/* src/pll_divider_search_core.sv */
// After accepting a request the controller stays in Run while it scans k feedback divider
// values (1 to FB_DIV_MAX-FB_DIV_MIN+1, at most 305), then Done registers valid_o.
// One feedback divider is tested per cycle, all post divider pairs in parallel.
// A new request is taken only once the last is through; busy is high from acceptance until the result
// cycle, in which the next request may be taken. The receiver cannot stall.
// Reset is asynchronous, active low; the reference register returns to 12000 kHz.
`default_nettype none

module pll_divider_search_core #(
  parameter int unsigned FB_DIV_MAX   = pds_pkg::FbDivMaxDefault,
  parameter int unsigned FB_DIV_MIN   = pds_pkg::FbDivMinDefault,
  parameter int unsigned POST_DIV_MAX = pds_pkg::PostDivMaxDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          ref_freq_khz_we_i,
  input  wire  [pds_pkg::RefW-1:0]     ref_freq_khz_i,
  input  wire                          start,
  output logic                         busy,
  input  wire  [pds_pkg::TargetW-1:0]  target_khz_i,
  output logic                         valid_o,
  output logic                         found_o,
  output logic [pds_pkg::VcoHzW-1:0]   vco_hz_o,
  output logic [pds_pkg::PostW-1:0]    pdiv1_o,
  output logic [pds_pkg::PostW-1:0]    pdiv2_o
);
  import pds_pkg::*;

  pds_cmd_t    cmd;
  pds_status_t status;

  // Sequencing of one request.
  pds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Scan and comparison logic.
  pds_datapath #(
    .FB_DIV_MAX   (FB_DIV_MAX),
    .FB_DIV_MIN   (FB_DIV_MIN),
    .POST_DIV_MAX (POST_DIV_MAX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ref_we_i     (ref_freq_khz_we_i),
    .ref_wdata_i  (ref_freq_khz_i),
    .target_khz_i (target_khz_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .valid_o      (valid_o),
    .found_o      (found_o),
    .vco_hz_o     (vco_hz_o),
    .pdiv1_o      (pdiv1_o),
    .pdiv2_o      (pdiv2_o)
  );

endmodule

`default_nettype wire
